// ===== rtl/core/phx_pkg.sv =====
// ----------------------------------------------------------------------------
// phx_pkg
// Shared types, constants and helpers for the Phoenix escape-time engine.
// ----------------------------------------------------------------------------
package phx_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 24;
    localparam int COUNT_BITS = 16;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int FLR_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = FLR_W + 3;
    localparam int MPROD_W    = COORD_BITS + 1 + DATA_W;
    localparam int MAP_W      = MPROD_W + 2;
    localparam int APB_ADDR_W = 5;
    localparam int Q_DEPTH    = 4;

    localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(25) << (2 * FRAC_BITS);

    localparam logic signed [DATA_W-1:0] RST_X_STEP    = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_X_ORIGIN  = -32'sd33554432;
    localparam logic signed [DATA_W-1:0] RST_Y_STEP    = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_Y_ORIGIN  = -32'sd33554432;
    localparam logic signed [DATA_W-1:0] RST_ADD_CONST = 32'sd9490000;
    localparam logic signed [DATA_W-1:0] RST_FB_GAIN   = -32'sd8388608;
    localparam logic [COUNT_BITS-1:0]    RST_ITER_LIM  = COUNT_BITS'(64);

    typedef enum logic [2:0] {
        REG_X_STEP     = 3'd0,
        REG_X_ORIGIN   = 3'd1,
        REG_Y_STEP     = 3'd2,
        REG_Y_ORIGIN   = 3'd3,
        REG_ADD_CONST  = 3'd4,
        REG_FB_GAIN    = 3'd5,
        REG_ITER_LIMIT = 3'd6
    } phx_reg_t;

    typedef enum logic [1:0] {
        PHX_IDLE,
        PHX_MUL,
        PHX_ADD
    } phx_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_step;
        logic signed [DATA_W-1:0] x_origin;
        logic signed [DATA_W-1:0] y_step;
        logic signed [DATA_W-1:0] y_origin;
        logic signed [DATA_W-1:0] add_const;
        logic signed [DATA_W-1:0] fb_gain;
        logic [COUNT_BITS-1:0]    iter_limit;
    } phx_cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } phx_point_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi) begin
            sat32 = hi[DATA_W-1:0];
        end else if (v < lo) begin
            sat32 = lo[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/phoenix_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// phoenix_escape_time_top
// Phoenix fractal escape-time counter: pixel beats in, iteration counts out.
// ----------------------------------------------------------------------------
// Each pixel beat is mapped to its start point through a registered product
// stage and placed in a four-entry queue, so the input side keeps taking
// beats while the iterator is busy, until the queue fills. Each point of the
// orbit passes through PHX_MUL, which registers the five 32 by 32 products,
// and PHX_ADD, which forms the sums, saturation and the escape test; a point
// is taken from the queue in PHX_IDLE. Results are held in an output
// register and one pixel is iterated at a time, in arrival order.
module phoenix_escape_time_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [phx_pkg::COORD_BITS-1:0] pixel_column,
    input  logic [phx_pkg::COORD_BITS-1:0] pixel_row,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [phx_pkg::COUNT_BITS-1:0] iteration_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [phx_pkg::DATA_W-1:0]    pwdata,
    output logic [phx_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import phx_pkg::*;

    phx_cfg_t   cfg;
    phx_point_t push_data;
    phx_point_t pop_data;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    phx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    phx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    phx_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_data          (pop_data),
        .pop             (pop),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .iteration_count (iteration_count)
    );

endmodule

// ===== rtl/core/phx_regs.sv =====
// ----------------------------------------------------------------------------
// phx_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module phx_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [phx_pkg::DATA_W-1:0]    pwdata,
    output logic [phx_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output phx_pkg::phx_cfg_t             cfg
);
    import phx_pkg::*;

    phx_cfg_t cfg_reg;
    phx_cfg_t cfg_next;
    phx_reg_t idx;
    logic     wr_en;

    assign idx    = phx_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_X_STEP:     cfg_next.x_step     = pwdata;
                REG_X_ORIGIN:   cfg_next.x_origin   = pwdata;
                REG_Y_STEP:     cfg_next.y_step     = pwdata;
                REG_Y_ORIGIN:   cfg_next.y_origin   = pwdata;
                REG_ADD_CONST:  cfg_next.add_const  = pwdata;
                REG_FB_GAIN:    cfg_next.fb_gain    = pwdata;
                REG_ITER_LIMIT: cfg_next.iter_limit = pwdata[COUNT_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_STEP:     prdata = cfg_reg.x_step;
            REG_X_ORIGIN:   prdata = cfg_reg.x_origin;
            REG_Y_STEP:     prdata = cfg_reg.y_step;
            REG_Y_ORIGIN:   prdata = cfg_reg.y_origin;
            REG_ADD_CONST:  prdata = cfg_reg.add_const;
            REG_FB_GAIN:    prdata = cfg_reg.fb_gain;
            REG_ITER_LIMIT: prdata = {{(DATA_W-COUNT_BITS){1'b0}}, cfg_reg.iter_limit};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.x_step     <= RST_X_STEP;
            cfg_reg.x_origin   <= RST_X_ORIGIN;
            cfg_reg.y_step     <= RST_Y_STEP;
            cfg_reg.y_origin   <= RST_Y_ORIGIN;
            cfg_reg.add_const  <= RST_ADD_CONST;
            cfg_reg.fb_gain    <= RST_FB_GAIN;
            cfg_reg.iter_limit <= RST_ITER_LIM;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/phx_front.sv =====
// ----------------------------------------------------------------------------
// phx_front
// Accepts pixel beats and maps each pixel to its complex start point.
// ----------------------------------------------------------------------------
module phx_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phx_pkg::phx_cfg_t             cfg,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [phx_pkg::COORD_BITS-1:0] pixel_column,
    input  logic [phx_pkg::COORD_BITS-1:0] pixel_row,
    output logic                          push,
    output phx_pkg::phx_point_t           push_data,
    input  logic                          q_full
);
    import phx_pkg::*;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic signed [MPROD_W-1:0]  col_prod_reg;
    logic signed [MPROD_W-1:0]  row_prod_reg;
    logic signed [MAP_W-1:0]    im_sum;
    logic signed [MAP_W-1:0]    re_sum;
    logic                       accept;

    assign pix_stall = s1_valid_reg && q_full;
    assign accept    = pix_valid && !pix_stall;
    assign push      = s1_valid_reg && !q_full;

    always_comb
    begin
        im_sum = {{(MAP_W-MPROD_W){col_prod_reg[MPROD_W-1]}}, col_prod_reg}
               + {{(MAP_W-DATA_W){cfg.x_origin[DATA_W-1]}}, cfg.x_origin};
        re_sum = -({{(MAP_W-MPROD_W){row_prod_reg[MPROD_W-1]}}, row_prod_reg}
               + {{(MAP_W-DATA_W){cfg.y_origin[DATA_W-1]}}, cfg.y_origin});
        push_data.im = sat32({{(PROD_W-MAP_W){im_sum[MAP_W-1]}}, im_sum});
        push_data.re = sat32({{(PROD_W-MAP_W){re_sum[MAP_W-1]}}, re_sum});
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            col_prod_reg <= MPROD_W'($signed({1'b0, pixel_column})) * MPROD_W'(cfg.x_step);
            row_prod_reg <= MPROD_W'($signed({1'b0, pixel_row})) * MPROD_W'(cfg.y_step);
        end
    end

endmodule

// ===== rtl/core/phx_queue.sv =====
// ----------------------------------------------------------------------------
// phx_queue
// Small first-in first-out queue of start points between front and back.
// ----------------------------------------------------------------------------
module phx_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  phx_pkg::phx_point_t push_data,
    input  logic                pop,
    output phx_pkg::phx_point_t pop_data,
    output logic                full,
    output logic                empty
);
    import phx_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    phx_point_t        entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/phx_back.sv =====
// ----------------------------------------------------------------------------
// phx_back
// Iterates the Phoenix map for one start point and holds the result beat.
// ----------------------------------------------------------------------------
module phx_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phx_pkg::phx_cfg_t             cfg,
    input  logic                          q_empty,
    input  phx_pkg::phx_point_t           q_data,
    output logic                          pop,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [phx_pkg::COUNT_BITS-1:0] iteration_count
);
    import phx_pkg::*;

    phx_state_t                state_reg;
    phx_state_t                state_next;
    logic signed [DATA_W-1:0]  re_reg;
    logic signed [DATA_W-1:0]  im_reg;
    logic signed [DATA_W-1:0]  pre_reg;
    logic signed [DATA_W-1:0]  pim_reg;
    logic signed [DATA_W-1:0]  re_next;
    logic signed [DATA_W-1:0]  im_next;
    logic signed [DATA_W-1:0]  pre_next;
    logic signed [DATA_W-1:0]  pim_next;
    logic [COUNT_BITS-1:0]     j_reg;
    logic [COUNT_BITS-1:0]     j_next;
    logic signed [PROD_W-1:0]  sq_re_reg;
    logic signed [PROD_W-1:0]  sq_im_reg;
    logic signed [PROD_W-1:0]  cross_reg;
    logic signed [PROD_W-1:0]  fb_re_reg;
    logic signed [PROD_W-1:0]  fb_im_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    logic [COUNT_BITS-1:0]     res_count_reg;
    logic [COUNT_BITS-1:0]     res_count_next;
    logic [COUNT_BITS-1:0]     lim_eff;
    logic [COUNT_BITS-1:0]     last_idx;
    logic [PROD_W-1:0]         mag2;
    logic                      esc;
    logic                      out_free;
    logic signed [SUM_W-1:0]   sum_re;
    logic signed [SUM_W-1:0]   sum_im;
    logic signed [FLR_W-1:0]   f_sq_re;
    logic signed [FLR_W-1:0]   f_sq_im;
    logic signed [FLR_W-1:0]   f_cross;
    logic signed [FLR_W-1:0]   f_fb_re;
    logic signed [FLR_W-1:0]   f_fb_im;

    assign res_valid       = res_valid_reg;
    assign iteration_count = res_count_reg;
    assign lim_eff         = (cfg.iter_limit == '0) ? COUNT_BITS'(1) : cfg.iter_limit;
    assign last_idx        = (lim_eff == COUNT_BITS'(1)) ? COUNT_BITS'(1)
                                                        : COUNT_BITS'(lim_eff - 1'b1);
    assign out_free        = !res_valid_reg || !res_stall;

    always_comb
    begin
        mag2    = sq_re_reg + sq_im_reg;
        esc     = (mag2 >= ESC_BOUND) && (j_reg != '0);
        f_sq_re = sq_re_reg[PROD_W-1:FRAC_BITS];
        f_sq_im = sq_im_reg[PROD_W-1:FRAC_BITS];
        f_cross = cross_reg[PROD_W-1:FRAC_BITS];
        f_fb_re = fb_re_reg[PROD_W-1:FRAC_BITS];
        f_fb_im = fb_im_reg[PROD_W-1:FRAC_BITS];
        sum_re  = {{(SUM_W-FLR_W){f_sq_re[FLR_W-1]}}, f_sq_re}
                - {{(SUM_W-FLR_W){f_sq_im[FLR_W-1]}}, f_sq_im}
                + {{(SUM_W-FLR_W){f_fb_re[FLR_W-1]}}, f_fb_re}
                + {{(SUM_W-DATA_W){cfg.add_const[DATA_W-1]}}, cfg.add_const};
        sum_im  = ({{(SUM_W-FLR_W){f_cross[FLR_W-1]}}, f_cross} <<< 1)
                + {{(SUM_W-FLR_W){f_fb_im[FLR_W-1]}}, f_fb_im};
    end

    always_comb
    begin
        state_next     = state_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        pre_next       = pre_reg;
        pim_next       = pim_reg;
        j_next         = j_reg;
        pop            = 1'b0;
        res_valid_next = res_valid_reg && res_stall;
        res_count_next = res_count_reg;
        unique case (state_reg)
            PHX_IDLE:
            begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    re_next    = q_data.re;
                    im_next    = q_data.im;
                    pre_next   = '0;
                    pim_next   = '0;
                    j_next     = '0;
                    state_next = PHX_MUL;
                end
            end
            PHX_MUL:
            begin
                state_next = PHX_ADD;
            end
            PHX_ADD:
            begin
                if (esc || (j_reg == last_idx)) begin
                    if (out_free) begin
                        res_valid_next = 1'b1;
                        if (esc) begin
                            res_count_next = (j_reg == COUNT_BITS'(1)) ? '0 : j_reg;
                        end else begin
                            res_count_next = lim_eff;
                        end
                        state_next = PHX_IDLE;
                    end
                end else begin
                    pre_next   = re_reg;
                    pim_next   = im_reg;
                    re_next    = sat32({{(PROD_W-SUM_W){sum_re[SUM_W-1]}}, sum_re});
                    im_next    = sat32({{(PROD_W-SUM_W){sum_im[SUM_W-1]}}, sum_im});
                    j_next     = COUNT_BITS'(j_reg + 1'b1);
                    state_next = PHX_MUL;
                end
            end
            default:
            begin
                state_next = PHX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= PHX_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg        <= re_next;
        im_reg        <= im_next;
        pre_reg       <= pre_next;
        pim_reg       <= pim_next;
        j_reg         <= j_next;
        res_count_reg <= res_count_next;
        if (state_reg == PHX_MUL) begin
            sq_re_reg <= re_reg * re_reg;
            sq_im_reg <= im_reg * im_reg;
            cross_reg <= re_reg * im_reg;
            fb_re_reg <= cfg.fb_gain * pre_reg;
            fb_im_reg <= cfg.fb_gain * pim_reg;
        end
    end

    ast_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_count_reg <= lim_eff))
        else $error("Result count exceeds the effective iteration limit.");

    ast_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PHX_ADD) |-> (j_reg <= last_idx))
        else $error("Iteration index ran past the last checked point.");

    ast_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == PHX_ADD))
        else $error("Result beat raised outside the accumulate step.");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Phoenix escape-time counter testbench
// Drives pixel beats through the block under randomised flow control, checks
// each count against a known value or a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phx_pkg::*;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 110;
    localparam int DRAIN_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRESSURE_LIM  = 8;

    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic        wr;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [11:0] col;
        logic [11:0] row;
        logic        typed;
        logic [15:0] want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    logic [COORD_BITS-1:0] pixel_column = '0;
    logic [COORD_BITS-1:0] pixel_row = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [COUNT_BITS-1:0] iteration_count;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic signed [31:0] cfg_x_step = 32'sd65536;
    logic signed [31:0] cfg_x_origin = -32'sd33554432;
    logic signed [31:0] cfg_y_step = 32'sd65536;
    logic signed [31:0] cfg_y_origin = -32'sd33554432;
    logic signed [31:0] cfg_add_const = 32'sd9490000;
    logic signed [31:0] cfg_fb_gain = -32'sd8388608;
    logic [15:0] cfg_iter_limit = 16'd64;

    logic [15:0] expected_counts[$];
    logic [15:0] wanted_count;
    step_t plan[$];
    int pixels_sent = 0;
    int counts_checked = 0;
    int error_count = 0;
    int settings_used = 1;
    int long_holds = 0;
    bit long_hold_wanted = 1'b0;

    phoenix_escape_time_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pixel_column(pixel_column),
        .pixel_row(pixel_row),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .iteration_count(iteration_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FRAC_BITS;
    endfunction

    function automatic bit out_of_bound(input logic signed [31:0] re, input logic signed [31:0] im);
        longint unsigned mr;
        longint unsigned mi;
        mr = longint'(re);
        mi = longint'(im);
        if (re < 0)
        begin
            mr = -longint'(re);
        end
        if (im < 0)
        begin
            mi = -longint'(im);
        end
        return (mr * mr + mi * mi) >= (64'd25 << (2 * FRAC_BITS));
    endfunction

    function automatic void phoenix_next(input logic signed [31:0] zr, input logic signed [31:0] zi,
                                         input logic signed [31:0] pr, input logic signed [31:0] pi,
                                         output logic signed [31:0] nr,
                                         output logic signed [31:0] ni);
        nr = clamp32(qmul(zr, zr) - qmul(zi, zi) + qmul(cfg_fb_gain, pr)
                     + longint'(cfg_add_const));
        ni = clamp32(2 * qmul(zr, zi) + qmul(cfg_fb_gain, pi));
    endfunction

    function automatic logic [15:0] predict_escape_count(input logic [11:0] col,
                                                         input logic [11:0] row);
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] pr;
        logic signed [31:0] pi;
        logic signed [31:0] nr;
        logic signed [31:0] ni;
        int unsigned cap;
        int unsigned k;
        logic [15:0] count;
        cap = (cfg_iter_limit == 16'd0) ? 1 : cfg_iter_limit;
        zi = clamp32(longint'(col) * longint'(cfg_x_step) + longint'(cfg_x_origin));
        zr = clamp32(-(longint'(row) * longint'(cfg_y_step) + longint'(cfg_y_origin)));
        pr = '0;
        pi = '0;
        phoenix_next(zr, zi, pr, pi, nr, ni);
        if (out_of_bound(nr, ni))
        begin
            return 16'd0;
        end
        count = cap[15:0];
        for (k = 2; k < cap; k++)
        begin
            pr = zr;
            pi = zi;
            zr = nr;
            zi = ni;
            phoenix_next(zr, zi, pr, pi, nr, ni);
            if (out_of_bound(nr, ni))
            begin
                count = k[15:0];
                break;
            end
        end
        return count;
    endfunction

    function automatic void store_setting(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_X_STEP:     cfg_x_step = data;
            REG_X_ORIGIN:   cfg_x_origin = data;
            REG_Y_STEP:     cfg_y_step = data;
            REG_Y_ORIGIN:   cfg_y_origin = data;
            REG_ADD_CONST:  cfg_add_const = data;
            REG_FB_GAIN:    cfg_fb_gain = data;
            REG_ITER_LIMIT: cfg_iter_limit = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic step_t beat_checked(input logic [11:0] c, input logic [11:0] r);
        return '{wr: 1'b0, idx: 3'd0, data: 32'd0, col: c, row: r, typed: 1'b0, want: 16'd0};
    endfunction

    function automatic step_t beat_known(input logic [11:0] c, input logic [11:0] r,
                                         input logic [15:0] w);
        return '{wr: 1'b0, idx: 3'd0, data: 32'd0, col: c, row: r, typed: 1'b1, want: w};
    endfunction

    function automatic step_t setting_row(input logic [2:0] i, input logic [31:0] d);
        return '{wr: 1'b1, idx: i, data: d, col: 12'd0, row: 12'd0, typed: 1'b0, want: 16'd0};
    endfunction

    function automatic logic [11:0] any_coord();
        case ($urandom_range(0, 15))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        store_setting(idx, data);
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input bit typed, input logic [15:0] want);
        pix_valid <= 1'b1;
        pixel_column <= col;
        pixel_row <= row;
        do @(posedge clk); while (pix_stall);
        expected_counts.push_back(typed ? want : predict_escape_count(col, row));
        pixels_sent++;
    endtask

    task automatic drain_counts();
        int guard;
        guard = 0;
        while (expected_counts.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_counts.size() != 0)
        begin
            $display("%0t: expected iteration_count %0d, none received (%0d outstanding)",
                     $time, expected_counts[0], expected_counts.size());
            error_count += expected_counts.size();
            expected_counts.delete();
        end
    endtask

    task automatic new_settings(input bit wild, input int lim_force);
        logic [31:0] xs;
        logic [31:0] xo;
        logic [31:0] ys;
        logic [31:0] yo;
        logic [31:0] ca;
        logic [31:0] fb;
        logic [15:0] lim;
        if (wild)
        begin
            xs = $urandom;
            xo = $urandom;
            ys = $urandom;
            yo = $urandom;
            ca = $urandom;
            fb = $urandom;
            lim = 16'($urandom_range(0, 30));
        end
        else
        begin
            xs = $urandom_range(8192, 24576);
            xo = int'($urandom_range(0, 16777216)) - 41943040;
            ys = $urandom_range(8192, 24576);
            yo = int'($urandom_range(0, 16777216)) - 41943040;
            if ($urandom_range(0, 3) == 0)
            begin
                xs = -xs;
                xo = -xo;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                ys = -ys;
                yo = -yo;
            end
            ca = int'($urandom_range(0, 16777216)) - 4194304;
            fb = int'($urandom_range(0, 25165824)) - 16777216;
            case ($urandom_range(0, 7))
                0: lim = 16'd0;
                1: lim = 16'd1;
                2: lim = 16'd2;
                6: lim = 16'($urandom_range(41, 120));
                7: lim = 16'($urandom_range(121, 200));
                default: lim = 16'($urandom_range(3, 40));
            endcase
        end
        if (lim_force >= 0)
        begin
            lim = lim_force[15:0];
        end
        apb_write(REG_X_STEP, xs);
        apb_write(REG_X_ORIGIN, xo);
        apb_write(REG_Y_STEP, ys);
        apb_write(REG_Y_ORIGIN, yo);
        apb_write(REG_ADD_CONST, ca);
        apb_write(REG_FB_GAIN, fb);
        apb_write(REG_ITER_LIMIT, {16'($urandom), lim});
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: iteration_count expected none, actual %0d", $time, iteration_count);
                error_count++;
            end
            else
            begin
                wanted_count = expected_counts.pop_front();
                counts_checked++;
                if (iteration_count !== wanted_count)
                begin
                    $display("%0t: iteration_count expected %0d, actual %0d",
                             $time, wanted_count, iteration_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int seg;
        int i;
        int cyc;
        cyc = 0;
        forever
        begin
            if (long_hold_wanted)
            begin
                for (i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                    res_stall <= 1'b1;
                end
                long_hold_wanted = 1'b0;
                long_holds++;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                seg = $urandom_range(8, 80);
                for (i = 0; i < seg; i++)
                begin
                    @(posedge clk);
                    cyc++;
                    case (mode)
                        0: res_stall <= 1'b0;
                        1: res_stall <= ($urandom_range(0, 3) == 0);
                        2: res_stall <= 1'($urandom_range(0, 1));
                        default: res_stall <= ((cyc % 7) < 3);
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        int burst_left;
        int gap;
        bit steady;
        plan = '{
            beat_known(0, 0, 0),
            beat_known(4095, 0, 0),
            beat_known(0, 4095, 0),
            beat_known(4095, 4095, 0),
            beat_checked(2048, 2048),
            beat_checked(12'hAAA, 12'h555),
            beat_checked(12'h555, 12'hAAA),
            setting_row(REG_X_ORIGIN, 32'd0),
            setting_row(REG_Y_ORIGIN, 32'd0),
            setting_row(REG_ADD_CONST, 32'd0),
            setting_row(REG_FB_GAIN, 32'd0),
            beat_known(0, 0, 64),
            beat_known(4095, 4095, 0),
            setting_row(REG_ITER_LIMIT, 32'd0),
            beat_known(0, 0, 1),
            beat_checked(1, 1),
            setting_row(REG_ITER_LIMIT, 32'd1),
            beat_known(0, 0, 1),
            beat_known(4095, 0, 0),
            setting_row(REG_SPARE, 32'hFFFF_FFFF),
            beat_known(0, 0, 1),
            setting_row(REG_X_STEP, 32'h7FFF_FFFF),
            setting_row(REG_ITER_LIMIT, 32'hFFFF_FFFF),
            beat_known(4095, 0, 0),
            beat_known(0, 0, 16'hFFFF),
            setting_row(REG_Y_STEP, 32'h8000_0000),
            setting_row(REG_Y_ORIGIN, 32'h7FFF_FFFF),
            beat_checked(4095, 4095),
            beat_checked(1, 2),
            setting_row(REG_X_ORIGIN, 32'h8000_0000),
            beat_checked(0, 4095)
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                pix_valid <= 1'b0;
                drain_counts();
                apb_write(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_pixel(plan[i].col, plan[i].row, plan[i].typed, plan[i].want);
            end
        end
        pix_valid <= 1'b0;
        drain_counts();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            new_settings(phase % 4 == 3, (phase == 2) ? PRESSURE_LIM : -1);
            steady = (phase % 3 == 1) || (phase == 2);
            if (phase == 2)
            begin
                long_hold_wanted = 1'b1;
            end
            burst_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = steady ? 0 : $urandom_range(0, 12);
                    if (gap > 0)
                    begin
                        pix_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
                send_pixel(any_coord(), any_coord(), 1'b0, 16'd0);
            end
            pix_valid <= 1'b0;
            drain_counts();
        end

        repeat (40) @(posedge clk);
        $display("Sent %0d pixel beats under %0d register settings, %0d counts checked.",
                 pixels_sent, settings_used, counts_checked);
        $display("Receiver held off for long stretches %0d time(s).", long_holds);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("%0t: timed out", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
